// ===== rtl/core/bpte_pkg.sv =====
// Shared types and constants for the Bezier point and tangent evaluator.
package bpte_pkg;

    // Field widths
    localparam int COORD_W    = 32;
    localparam int T_FRAC     = 16;
    localparam int T_W        = T_FRAC + 1;
    localparam int TAN_W      = COORD_W + 1;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = DIFF_W + T_W;
    localparam int ACT_W      = 2;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W  = 280;
    localparam int M_TDATA_W  = 136;
    localparam int M_PAD_W    = M_TDATA_W - 2 * COORD_W - 2 * TAN_W;

    // Pipeline depth: three levels of three-stage interpolators
    localparam int LERP_STAGES = 3;
    localparam int NUM_STAGES  = 3 * LERP_STAGES;

    // Degree codes on the input
    localparam logic [ACT_W-1:0] ACT_LINE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_QUAD  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CUBIC = 2'd2;

    // 1.0 in Q1.16
    localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [TAN_W-1:0]   tan_t;
    typedef logic        [T_W-1:0]     t_t;

    typedef enum logic [1:0] {
        DEG_LINE  = 2'd0,
        DEG_QUAD  = 2'd1,
        DEG_CUBIC = 2'd2
    } deg_t;

    // Side data that travels with each pipeline stage
    typedef struct packed {
        deg_t   deg;
        t_t     t;
        coord_t pt_x;
        coord_t pt_y;
        tan_t   tan_x;
        tan_t   tan_y;
    } side_t;

endpackage

// ===== rtl/core/bezier_point_and_tangent_eval.sv =====
// Top level of the De Casteljau Bezier point and tangent evaluator.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata: t, 4 control points; tuser: degree
//  m_      | out | m_tvalid/m_tready  | tdata: point x/y, tangent x/y
//
// One beat per cycle is sustained while m_ is not stalled. A result passes through
// three interpolation levels of three stages each (subtract, 33x18 multiply,
// add), then the output register.
// Reset clears the valid bits only. A stall on m_ freezes the whole pipeline,
// and s_tready is low while it lasts.
module bezier_point_and_tangent_eval (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata, low bit up: param_t[16:0], start_x, start_y, ctrl_a_x, ctrl_a_y,
    // ctrl_b_x, ctrl_b_y, end_x, end_y (32 bits each), 7 zero bits
    input  logic [bpte_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: action[1:0]
    input  logic [bpte_pkg::ACT_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata, low bit up: point_x (32), point_y (32), tangent_x (33),
    // tangent_y (33), 6 zero bits
    output logic [bpte_pkg::M_TDATA_W-1:0] m_tdata
);
    import bpte_pkg::*;

    logic                   adv;
    coord_t                 start_x, start_y, ctrl_a_x, ctrl_a_y;
    coord_t                 ctrl_b_x, ctrl_b_y, end_x, end_y;
    t_t                     t_in, t_clamp;
    deg_t                   deg_in;
    coord_t                 q    [0:1][0:3];
    coord_t                 lv1  [0:1][0:2];
    coord_t                 lv2  [0:1][0:1];
    coord_t                 lv3  [0:1];
    side_t                  sb_reg  [1:NUM_STAGES];
    side_t                  sb_next [1:NUM_STAGES];
    logic [NUM_STAGES:1]    vld_reg, vld_next;
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    coord_t                 out_px, out_py;

    // Whole pipeline moves when the output register is free
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // Unpack the input beat
    assign t_in     = s_tdata[16:0];
    assign start_x  = s_tdata[48:17];
    assign start_y  = s_tdata[80:49];
    assign ctrl_a_x = s_tdata[112:81];
    assign ctrl_a_y = s_tdata[144:113];
    assign ctrl_b_x = s_tdata[176:145];
    assign ctrl_b_y = s_tdata[208:177];
    assign end_x    = s_tdata[240:209];
    assign end_y    = s_tdata[272:241];

    // Clamp t to 1.0 and decode the degree; the spare code reads as cubic
    always_comb begin
        t_clamp = (t_in > T_ONE) ? T_ONE : t_in;
        unique case (s_tuser)
            ACT_LINE: deg_in = DEG_LINE;
            ACT_QUAD: deg_in = DEG_QUAD;
            default:  deg_in = DEG_CUBIC;
        endcase
    end

    // Arrange control points so that level one serves every degree
    always_comb begin
        q[0][0] = start_x;
        q[1][0] = start_y;
        q[0][1] = (deg_in == DEG_LINE) ? end_x : ctrl_a_x;
        q[1][1] = (deg_in == DEG_LINE) ? end_y : ctrl_a_y;
        q[0][2] = (deg_in == DEG_QUAD) ? end_x : ctrl_b_x;
        q[1][2] = (deg_in == DEG_QUAD) ? end_y : ctrl_b_y;
        q[0][3] = end_x;
        q[1][3] = end_y;
    end

    // Interpolator levels, one set per axis
    for (genvar ax = 0; ax < 2; ax++) begin : g_axis
        for (genvar i = 0; i < 3; i++) begin : g_lv1
            bpte_lerp u_lerp (
                .aclk (aclk),
                .en   (adv),
                .a    (q[ax][i]),
                .b    (q[ax][i+1]),
                .t    (t_clamp),
                .y    (lv1[ax][i])
            );
        end
        for (genvar i = 0; i < 2; i++) begin : g_lv2
            bpte_lerp u_lerp (
                .aclk (aclk),
                .en   (adv),
                .a    (lv1[ax][i]),
                .b    (lv1[ax][i+1]),
                .t    (sb_reg[LERP_STAGES].t),
                .y    (lv2[ax][i])
            );
        end
        bpte_lerp u_lv3 (
            .aclk (aclk),
            .en   (adv),
            .a    (lv2[ax][0]),
            .b    (lv2[ax][1]),
            .t    (sb_reg[2*LERP_STAGES].t),
            .y    (lv3[ax])
        );
    end

    // Side data: pick up the point and tangent at the level that finishes them
    always_comb begin
        sb_next[1].deg   = deg_in;
        sb_next[1].t     = t_clamp;
        sb_next[1].pt_x  = '0;
        sb_next[1].pt_y  = '0;
        sb_next[1].tan_x = TAN_W'(end_x) - TAN_W'(start_x);
        sb_next[1].tan_y = TAN_W'(end_y) - TAN_W'(start_y);
        for (int k = 2; k <= NUM_STAGES; k++) begin
            sb_next[k] = sb_reg[k-1];
        end
        // after level one: line point, quadratic tangent
        if (sb_reg[LERP_STAGES].deg == DEG_LINE) begin
            sb_next[LERP_STAGES+1].pt_x = lv1[0][0];
            sb_next[LERP_STAGES+1].pt_y = lv1[1][0];
        end
        if (sb_reg[LERP_STAGES].deg == DEG_QUAD) begin
            sb_next[LERP_STAGES+1].tan_x = TAN_W'(lv1[0][1]) - TAN_W'(lv1[0][0]);
            sb_next[LERP_STAGES+1].tan_y = TAN_W'(lv1[1][1]) - TAN_W'(lv1[1][0]);
        end
        // after level two: quadratic point, cubic tangent
        if (sb_reg[2*LERP_STAGES].deg == DEG_QUAD) begin
            sb_next[2*LERP_STAGES+1].pt_x = lv2[0][0];
            sb_next[2*LERP_STAGES+1].pt_y = lv2[1][0];
        end
        if (sb_reg[2*LERP_STAGES].deg == DEG_CUBIC) begin
            sb_next[2*LERP_STAGES+1].tan_x = TAN_W'(lv2[0][1]) - TAN_W'(lv2[0][0]);
            sb_next[2*LERP_STAGES+1].tan_y = TAN_W'(lv2[1][1]) - TAN_W'(lv2[1][0]);
        end
    end

    // Valid bits move with the data
    assign vld_next = {vld_reg[NUM_STAGES-1:1], s_tvalid};

    // Output beat: cubic point comes from the last level
    always_comb begin
        out_px = (sb_reg[NUM_STAGES].deg == DEG_CUBIC) ? lv3[0] : sb_reg[NUM_STAGES].pt_x;
        out_py = (sb_reg[NUM_STAGES].deg == DEG_CUBIC) ? lv3[1] : sb_reg[NUM_STAGES].pt_y;
        m_tdata_next = {{M_PAD_W{1'b0}}, sb_reg[NUM_STAGES].tan_y,
                        sb_reg[NUM_STAGES].tan_x, out_py, out_px};
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg      <= vld_next;
            m_tvalid_reg <= vld_reg[NUM_STAGES];
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 1; k <= NUM_STAGES; k++) begin
                sb_reg[k] <= sb_next[k];
            end
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Reset empties the output
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // An accepted beat enters the first stage
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[1])
        else $error("accepted beat lost at pipeline entry");

    // A stall holds every valid bit in place
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg) && $stable(sb_reg[NUM_STAGES]))
        else $error("pipeline moved during stall");

    // The last stage drains into the output register
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[NUM_STAGES] && adv |=> m_tvalid)
        else $error("last stage beat dropped");

    // Ready follows the output register state
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

endmodule

// ===== rtl/core/bpte_lerp.sv =====
// Three-stage linear interpolator: y = a + floor((b - a) * t / 2^16).
module bpte_lerp (
    input  logic            aclk,
    input  logic            en,
    input  bpte_pkg::coord_t a,
    input  bpte_pkg::coord_t b,
    input  bpte_pkg::t_t     t,
    output bpte_pkg::coord_t y
);
    import bpte_pkg::*;

    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    coord_t                   a1_reg, a2_reg;
    t_t                       t1_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    coord_t                   y_reg, y_next;

    // Stage 1 difference, stage 2 product, stage 3 floor shift and add
    always_comb begin
        diff_next = DIFF_W'(b) - DIFF_W'(a);
        prod_next = PROD_W'(diff_reg) * PROD_W'($signed({1'b0, t1_reg}));
        // low word of the sum is exact: the result stays between a and b
        y_next    = a2_reg + coord_t'(prod_reg[T_FRAC +: COORD_W]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_reg <= diff_next;
            a1_reg   <= a;
            t1_reg   <= t;
            prod_reg <= prod_next;
            a2_reg   <= a1_reg;
            y_reg    <= y_next;
        end
    end

    assign y = y_reg;

endmodule
